// File: src/assert_macros.svh
// Assertion macros used by the mutex RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PHM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define PHM_ASSERT(lbl, prop, msg)
`define PHM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: src/phm_pkg.sv
// Types and constants of the priority handoff mutex.
package phm_pkg;

  localparam int unsigned MaxWaiters = 8;
  localparam int unsigned TaskW      = 3;
  localparam int unsigned PrioW      = 8;

  typedef enum logic [2:0] {
    StAcquired = 3'd0,
    StAlready  = 3'd1,
    StQueued   = 3'd2,
    StFreed    = 3'd3,
    StHandoff  = 3'd4,
    StNotOwner = 3'd5,
    StInIsr    = 3'd6,
    StFull     = 3'd7
  } status_e;

  typedef enum logic {
    OpLock   = 1'b0,
    OpUnlock = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CmdHold = 2'd0,
    CmdPush = 2'd1,
    CmdPop  = 2'd2
  } cell_cmd_e;

  // Broadcast to every cell of the wait queue.
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] prio;
  } cell_ctrl_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic             present;
    logic             keep;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] prio;
  } slot_t;

endpackage

// File: src/phm_cell.sv
// One slot of the wait queue, kept sorted by priority then arrival.
module phm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  phm_pkg::cell_ctrl_t ctrl_i,
  input  phm_pkg::slot_t    prev_i,
  input  phm_pkg::slot_t    next_i,
  output phm_pkg::slot_t    slot_o
);

  logic                      present_q, present_d;
  logic [phm_pkg::TaskW-1:0] task_q, task_d;
  logic [phm_pkg::PrioW-1:0] prio_q, prio_d;
  logic                      keep;

  // Entries at least as urgent as the new one stay; equal priority stays ahead.
  assign keep = present_q && (prio_q <= ctrl_i.prio);

  always_comb begin
    present_d = present_q;
    task_d    = task_q;
    prio_d    = prio_q;
    case (ctrl_i.cmd)
      phm_pkg::CmdPush: begin
        if (keep) begin
          present_d = present_q;
        end else if (prev_i.keep) begin
          present_d = 1'b1;
          task_d    = ctrl_i.task_id;
          prio_d    = ctrl_i.prio;
        end else begin
          present_d = prev_i.present;
          task_d    = prev_i.task_id;
          prio_d    = prev_i.prio;
        end
      end
      phm_pkg::CmdPop: begin
        present_d = next_i.present;
        task_d    = next_i.task_id;
        prio_d    = next_i.prio;
      end
      default: begin
        present_d = present_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else begin
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    prio_q <= prio_d;
  end

  assign slot_o = '{present: present_q, keep: keep, task_id: task_q, prio: prio_q};

endmodule

// File: src/priority_handoff_mutex.sv
// Priority handoff mutex: request decode, owner state and a sorted chain of queue cells.
// Latency: a request's result word is registered, and shown in the cycle after the request is accepted.
// One request per cycle while ready; the queue cells settle a push or pop in that cycle.
// A request is accepted whenever the result register is empty or being drained.
// Reset (rst_ni low, asynchronous): mutex free, no owner, queue empty, no result pending.
`include "assert_macros.svh"

module priority_handoff_mutex (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // task_id[2:0], task_priority[10:3], zero pad
  input  logic [1:0]  s_axis_tuser,  // op[0], from_interrupt[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // status[2:0], wake_valid[3], wake_task[6:4], zero pad
);

  localparam int unsigned N = phm_pkg::MaxWaiters;

  logic                      owner_valid_q, owner_valid_d;
  logic [phm_pkg::TaskW-1:0] owner_task_q, owner_task_d;
  logic                      out_valid_q;
  logic [7:0]                out_data_q;

  phm_pkg::slot_t     slots [N];
  phm_pkg::slot_t     prev_link [N];
  phm_pkg::slot_t     next_link [N];
  phm_pkg::cell_ctrl_t ctrl;

  logic                      accept;
  phm_pkg::op_e              op;
  logic                      from_isr;
  logic [phm_pkg::TaskW-1:0] req_task;
  logic [phm_pkg::PrioW-1:0] req_prio;
  logic                      is_owner;
  phm_pkg::status_e          status;
  logic                      wake_valid;
  logic [phm_pkg::TaskW-1:0] wake_task;
  phm_pkg::cell_cmd_e        cmd;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign op       = phm_pkg::op_e'(s_axis_tuser[0]);
  assign from_isr = s_axis_tuser[1];
  assign req_task = s_axis_tdata[2:0];
  assign req_prio = s_axis_tdata[10:3];
  assign is_owner = owner_valid_q && (owner_task_q == req_task);

  always_comb begin
    status        = phm_pkg::StInIsr;
    wake_valid    = 1'b0;
    wake_task     = '0;
    cmd           = phm_pkg::CmdHold;
    owner_valid_d = owner_valid_q;
    owner_task_d  = owner_task_q;
    if (from_isr) begin
      status = phm_pkg::StInIsr;
    end else if (op == phm_pkg::OpLock) begin
      if (is_owner) begin
        status = phm_pkg::StAlready;
      end else if (!owner_valid_q) begin
        status        = phm_pkg::StAcquired;
        owner_valid_d = 1'b1;
        owner_task_d  = req_task;
      end else if (slots[N-1].present) begin
        status = phm_pkg::StFull;
      end else begin
        status = phm_pkg::StQueued;
        cmd    = phm_pkg::CmdPush;
      end
    end else if (!is_owner) begin
      status = phm_pkg::StNotOwner;
    end else if (!slots[0].present) begin
      status        = phm_pkg::StFreed;
      owner_valid_d = 1'b0;
      owner_task_d  = '0;
    end else begin
      // Head of the sorted queue is the most urgent, earliest waiter.
      status       = phm_pkg::StHandoff;
      wake_valid   = 1'b1;
      wake_task    = slots[0].task_id;
      owner_task_d = slots[0].task_id;
      cmd          = phm_pkg::CmdPop;
    end
    if (!accept) begin
      cmd = phm_pkg::CmdHold;
    end
  end

  assign ctrl = '{cmd: cmd, task_id: req_task, prio: req_prio};

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_link[i] = '{present: 1'b1, keep: 1'b1, task_id: '0, prio: '0};
    end else begin : g_body
      assign prev_link[i] = slots[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_link[i] = '{present: 1'b0, keep: 1'b0, task_id: '0, prio: '0};
    end else begin : g_inner
      assign next_link[i] = slots[i+1];
    end
    phm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_link[i]),
      .next_i (next_link[i]),
      .slot_o (slots[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_valid_q <= 1'b0;
      owner_task_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        owner_valid_q <= owner_valid_d;
        owner_task_q  <= owner_task_d;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, wake_task, wake_valid, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PHM_ASSERT(a_waiters_need_owner, slots[0].present |-> owner_valid_q, "waiter queued while mutex free")
  `PHM_ASSERT(a_queue_compact, slots[1].present |-> slots[0].present, "queue has a hole at the head")
  `PHM_ASSERT(a_queue_sorted, (slots[0].present && slots[1].present) |-> (slots[0].prio <= slots[1].prio), "queue head out of priority order")
  `PHM_ASSERT_NEXT(a_handoff_sets_owner, accept && (cmd == phm_pkg::CmdPop), owner_valid_q && (owner_task_q == m_axis_tdata[6:4]), "handoff did not move ownership")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the priority handoff mutex.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomWordsPerPhase = 312;
  localparam int unsigned MaxReports = 20;

  // Predicts the mutex and holds the result words still owed by the block.
  class mutex_scoreboard;
    typedef struct {
      logic [phm_pkg::TaskW-1:0] task_id;
      logic [phm_pkg::PrioW-1:0] prio;
    } waiter_t;

    typedef struct {
      phm_pkg::status_e          status;
      logic                      wake;
      logic [phm_pkg::TaskW-1:0] wake_task;
    } verdict_t;

    bit                        locked;
    logic [phm_pkg::TaskW-1:0] owner;
    waiter_t                   waiters[$];
    verdict_t                  owed_q[$];
    int unsigned               errors;

    function new();
      locked = 1'b0;
      owner  = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < MaxReports) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Advance the mutex by one accepted request and queue its result word.
    task note_request(phm_pkg::op_e op, logic [phm_pkg::TaskW-1:0] tid,
                      logic [phm_pkg::PrioW-1:0] prio, logic isr);
      verdict_t v;
      waiter_t  w;
      int       best;
      v.status    = phm_pkg::StAcquired;
      v.wake      = 1'b0;
      v.wake_task = '0;
      if (isr) begin
        v.status = phm_pkg::StInIsr;
      end else if (op == phm_pkg::OpLock) begin
        if (locked && owner == tid) begin
          v.status = phm_pkg::StAlready;
        end else if (!locked) begin
          locked   = 1'b1;
          owner    = tid;
          v.status = phm_pkg::StAcquired;
        end else if (waiters.size() >= phm_pkg::MaxWaiters) begin
          v.status = phm_pkg::StFull;
        end else begin
          w.task_id = tid;
          w.prio    = prio;
          waiters.push_back(w);
          v.status = phm_pkg::StQueued;
        end
      end else if (!(locked && owner == tid)) begin
        v.status = phm_pkg::StNotOwner;
      end else if (waiters.size() == 0) begin
        locked   = 1'b0;
        owner    = '0;
        v.status = phm_pkg::StFreed;
      end else begin
        // strict compare: the earliest arrival wins a tie
        best = 0;
        for (int i = 1; i < waiters.size(); i++)
          if (waiters[i].prio < waiters[best].prio) best = i;
        owner = waiters[best].task_id;
        waiters.delete(best);
        v.status    = phm_pkg::StHandoff;
        v.wake      = 1'b1;
        v.wake_task = owner;
      end
      owed_q.push_back(v);
    endtask

    task check_result(logic [7:0] word);
      verdict_t         v;
      phm_pkg::status_e got_status;
      got_status = phm_pkg::status_e'(word[2:0]);
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing owed", word));
      end else begin
        v = owed_q.pop_front();
        if (got_status != v.status)
          report_mismatch($sformatf("status %s, want %s", got_status.name(), v.status.name()));
        if (word[3] != v.wake)
          report_mismatch($sformatf("wake_valid %b, want %b", word[3], v.wake));
        if (word[6:4] != v.wake_task)
          report_mismatch($sformatf("wake_task %0d, want %0d", word[6:4], v.wake_task));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycles = 0;

  mutex_scoreboard sb = new();

  priority_handoff_mutex dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(phm_pkg::op_e op, logic [phm_pkg::TaskW-1:0] tid,
                           logic [phm_pkg::PrioW-1:0] prio, logic isr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, prio, tid};
    s_axis_tuser  <= {isr, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, tid, prio, isr);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed result word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed traffic: owners unlock, others contend for the lock.
  task automatic send_random_word();
    phm_pkg::op_e              op;
    logic [phm_pkg::TaskW-1:0] tid;
    logic [phm_pkg::PrioW-1:0] prio;
    logic                      isr;
    isr = ($urandom_range(0, 99) < 4);
    tid = phm_pkg::TaskW'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1:       prio = phm_pkg::PrioW'($urandom_range(0, 3));
      default: prio = phm_pkg::PrioW'($urandom_range(0, 255));
    endcase
    if (sb.locked) begin
      op = ($urandom_range(0, 99) < 45) ? phm_pkg::OpUnlock : phm_pkg::OpLock;
      if ((op == phm_pkg::OpUnlock && $urandom_range(0, 99) < 85) ||
          (op == phm_pkg::OpLock && $urandom_range(0, 99) < 8))
        tid = sb.owner;
    end else begin
      op = ($urandom_range(0, 99) < 10) ? phm_pkg::OpUnlock : phm_pkg::OpLock;
    end
    send_word(op, tid, prio, isr);
  endtask

  initial begin
    int unsigned idle_pct[4];
    int unsigned stall_pct[4];
    idle_pct  = '{0, 61, 0, 12};
    stall_pct = '{0, 0, 61, 12};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: free-unlock, interrupt, acquire, relock, fill, overflow, handoffs
    send_word(phm_pkg::OpUnlock, 3'd3, 8'd0, 1'b0);
    send_word(phm_pkg::OpLock, 3'd0, 8'd255, 1'b1);
    send_word(phm_pkg::OpLock, 3'd0, 8'd10, 1'b0);
    send_word(phm_pkg::OpLock, 3'd0, 8'd10, 1'b0);
    send_word(phm_pkg::OpLock, 3'd7, 8'd255, 1'b0);
    send_word(phm_pkg::OpLock, 3'd1, 8'd0, 1'b0);
    send_word(phm_pkg::OpLock, 3'd2, 8'd0, 1'b0);
    send_word(phm_pkg::OpLock, 3'd7, 8'd5, 1'b0);
    send_word(phm_pkg::OpLock, 3'd3, 8'd200, 1'b0);
    send_word(phm_pkg::OpLock, 3'd4, 8'd128, 1'b0);
    send_word(phm_pkg::OpLock, 3'd5, 8'd255, 1'b0);
    send_word(phm_pkg::OpLock, 3'd6, 8'd1, 1'b0);
    send_word(phm_pkg::OpLock, 3'd1, 8'd0, 1'b0);
    send_word(phm_pkg::OpUnlock, 3'd2, 8'd0, 1'b0);
    send_word(phm_pkg::OpUnlock, 3'd0, 8'd255, 1'b1);
    repeat (9) send_word(phm_pkg::OpUnlock, sb.owner, 8'd0, 1'b0);

    wait_drained();

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_pct[p];
      sink_stall_pct  = stall_pct[p];
      repeat (RandomWordsPerPhase) send_random_word();
    end

    sink_stall_pct = 0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
